// ----- rtl/mqpha_pkg.sv -----
package mqpha_pkg;

   localparam int MaxLinesDefault  = 16;
   localparam int LineDepthDefault = 64;

   // arrival counter and served counter widths
   localparam int ArrivalW = 11;
   localparam int ServedW  = 10;
   localparam int CsrIdxW  = 4;
   localparam int CsrDataW = 16;

   // register indexes
   localparam logic [CsrIdxW-1:0] RegLinesInUse = 4'd0;
   localparam logic [CsrIdxW-1:0] RegTargetIdx  = 4'd1;

   localparam logic [4:0] LinesInUseReset = 5'd4;

   // result status codes
   localparam logic [1:0] StatusOk    = 2'd0;
   localparam logic [1:0] StatusFull  = 2'd1;
   localparam logic [1:0] StatusEmpty = 2'd2;

   localparam logic ModePush = 1'b0;

   typedef struct packed {
      logic        mode;
      logic [15:0] days;
      logic [15:0] urgency;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  line;
      logic [15:0] served_days;
      logic [15:0] served_urgency;
      logic        is_target;
      logic [9:0]  order_number;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SETSEL,
      ST_PUSH,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_SERVE,
      ST_POP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic div_step;
      logic set_sel;
      logic push;
      logic scan_rd;
      logic scan_cmp;
      logic sel_best;
      logic pop;
      logic rsp_empty;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_done;
      logic scan_last;
      logic best_found;
      logic rsp_busy;
   } stat_type;

endpackage

// ----- rtl/multi_queue_priority_head_arbiter_top.sv -----
// Channel  Ports                                  Direction  Payload
// req      req_valid, req_stall, req_data         in         mqpha_pkg::req_type
// rsp      rsp_valid, rsp_stall, rsp_data         out        mqpha_pkg::rsp_type
// csr      csr_valid, csr_ready, csr_index/wdata  in         register writes
//
// A push first runs the bit-serial remainder that picks the line (11 steps and
// a done check), then select and write.
// A serve reads each line's head from the entry store and compares it in turn,
// then pops the best head (an empty status when every line is empty).
// One item is in work at a time; the next is taken in the cycle after a result is
// written, and a result held by rsp_stall holds the next item in its last state.
// Reset (synchronous) clears all pointers and counts at once.
module multi_queue_priority_head_arbiter_top #(
   parameter int MAX_LINES  = mqpha_pkg::MaxLinesDefault,
   parameter int LINE_DEPTH = mqpha_pkg::LineDepthDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  mqpha_pkg::req_type             req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output mqpha_pkg::rsp_type             rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mqpha_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [mqpha_pkg::CsrDataW-1:0] csr_wdata
);

   mqpha_pkg::cmd_type  cmd;
   mqpha_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   mqpha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_data.mode),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   mqpha_dpath #(
      .MAX_LINES  (MAX_LINES),
      .LINE_DEPTH (LINE_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

// ----- rtl/mqpha_ctrl.sv -----
module mqpha_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_mode,
   output logic                  req_stall,
   input  mqpha_pkg::stat_type   stat,
   output mqpha_pkg::cmd_type    cmd
);

   mqpha_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mqpha_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         mqpha_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in = (req_mode == mqpha_pkg::ModePush) ?
                          mqpha_pkg::ST_DIV : mqpha_pkg::ST_SCAN_RD;
            end
         end
         mqpha_pkg::ST_DIV: begin
            if (stat.div_done) begin
               state_in = mqpha_pkg::ST_SETSEL;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         mqpha_pkg::ST_SETSEL: begin
            cmd.set_sel = 1'b1;
            state_in = mqpha_pkg::ST_PUSH;
         end
         // hold until the result register can take the push result
         mqpha_pkg::ST_PUSH: begin
            if (!stat.rsp_busy) begin
               cmd.push = 1'b1;
               state_in = mqpha_pkg::ST_IDLE;
            end
         end
         mqpha_pkg::ST_SCAN_RD: begin
            cmd.scan_rd = 1'b1;
            state_in = mqpha_pkg::ST_SCAN_CMP;
         end
         mqpha_pkg::ST_SCAN_CMP: begin
            cmd.scan_cmp = 1'b1;
            state_in = stat.scan_last ? mqpha_pkg::ST_SERVE : mqpha_pkg::ST_SCAN_RD;
         end
         mqpha_pkg::ST_SERVE: begin
            if (stat.best_found) begin
               cmd.sel_best = 1'b1;
               state_in = mqpha_pkg::ST_POP;
            end else if (!stat.rsp_busy) begin
               cmd.rsp_empty = 1'b1;
               state_in = mqpha_pkg::ST_IDLE;
            end
         end
         // hold until the result register can take the served entry
         mqpha_pkg::ST_POP: begin
            if (!stat.rsp_busy) begin
               cmd.pop = 1'b1;
               state_in = mqpha_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mqpha_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/mqpha_dpath.sv -----
module mqpha_dpath #(
   parameter int MAX_LINES  = mqpha_pkg::MaxLinesDefault,
   parameter int LINE_DEPTH = mqpha_pkg::LineDepthDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mqpha_pkg::req_type                req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output mqpha_pkg::rsp_type                rsp_data,
   input  logic                              csr_valid,
   input  logic [mqpha_pkg::CsrIdxW-1:0]     csr_index,
   input  logic [mqpha_pkg::CsrDataW-1:0]    csr_wdata,
   input  mqpha_pkg::cmd_type                cmd,
   output mqpha_pkg::stat_type               stat
);

   localparam int LW    = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
   localparam int PW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int CW    = $clog2(LINE_DEPTH + 1);
   localparam int MW    = $clog2(MAX_LINES + 1);
   localparam int AW    = $clog2(MAX_LINES * LINE_DEPTH);
   localparam int DEPTH = MAX_LINES * LINE_DEPTH;
   localparam int AcW   = mqpha_pkg::ArrivalW;
   localparam int SvW   = mqpha_pkg::ServedW;

   // configuration
   logic [4:0]      lines_ff;
   logic [SvW-1:0]  target_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lines_ff  <= mqpha_pkg::LinesInUseReset;
         target_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == mqpha_pkg::RegLinesInUse) begin
            lines_ff <= csr_wdata[4:0];
         end else if (csr_index == mqpha_pkg::RegTargetIdx) begin
            target_ff <= csr_wdata[SvW-1:0];
         end
      end
   end

   // clamp the line count to 1..MAX_LINES
   logic [MW-1:0] lines_m;
   always_comb begin
      if (lines_ff == 5'd0) begin
         lines_m = MW'(1);
      end else if (32'(lines_ff) > MAX_LINES) begin
         lines_m = MW'(MAX_LINES);
      end else begin
         lines_m = MW'(lines_ff);
      end
   end

   // latched item and counters
   logic [15:0]     days_ff, urg_ff;
   logic [AcW-1:0]  arrival_ff;
   logic [SvW-1:0]  served_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         days_ff <= req_data.days;
         urg_ff  <= req_data.urgency;
      end
   end

   // remainder of arrival by line count, one bit a cycle
   logic [3:0]      div_cnt_ff;
   logic [MW:0]     rem_ff, rem_shift, rem_in;

   always_comb begin
      rem_shift = {rem_ff[MW-1:0], arrival_ff[4'(AcW - 1) - div_cnt_ff]};
      rem_in    = (rem_shift >= (MW+1)'(lines_m)) ?
                  rem_shift - (MW+1)'(lines_m) : rem_shift;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.accept) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
      end
   end

   // per-line pointers and counts, read at the selected line only
   logic [PW-1:0]  head_ff [MAX_LINES];
   logic [PW-1:0]  tail_ff [MAX_LINES];
   logic [CW-1:0]  cnt_ff  [MAX_LINES];
   logic [LW-1:0]  sel_ff;
   logic [PW-1:0]  sel_head, sel_tail;
   logic [CW-1:0]  sel_cnt;
   logic           line_full;

   assign sel_head  = head_ff[sel_ff];
   assign sel_tail  = tail_ff[sel_ff];
   assign sel_cnt   = cnt_ff[sel_ff];
   assign line_full = (sel_cnt == CW'(LINE_DEPTH));

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      next_ptr = (p == PW'(LINE_DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   // best-head tracking
   logic           best_found_ff;
   logic [LW-1:0]  best_ff;
   logic [32:0]    best_data_ff;
   logic [32:0]    rd_data_ff;
   logic           scan_last;

   assign scan_last = (sel_ff == LW'(MAX_LINES - 1));

   // select line, advance the scan
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= '0;
      end else if (cmd.accept) begin
         sel_ff <= '0;
      end else if (cmd.set_sel) begin
         sel_ff <= LW'(rem_ff);
      end else if (cmd.sel_best) begin
         sel_ff <= best_ff;
      end else if (cmd.scan_cmp && !scan_last) begin
         sel_ff <= sel_ff + LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_found_ff <= 1'b0;
      end else if (cmd.accept) begin
         best_found_ff <= 1'b0;
      end else if (cmd.scan_cmp && (sel_cnt != '0) &&
                   (!best_found_ff || rd_data_ff[31:0] > best_data_ff[31:0])) begin
         best_found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_cmp && (sel_cnt != '0) &&
          (!best_found_ff || rd_data_ff[31:0] > best_data_ff[31:0])) begin
         best_ff      <= sel_ff;
         best_data_ff <= rd_data_ff;
      end
   end

   // entry store
   logic [32:0]   mem [DEPTH];
   logic [AW-1:0] mem_addr;
   logic          mark;

   assign mark     = (arrival_ff == AcW'(target_ff));
   assign mem_addr = AW'(sel_ff) * AW'(LINE_DEPTH) +
                     AW'(cmd.push ? sel_tail : sel_head);

   always_ff @(posedge clock) begin
      if (cmd.push && !line_full) begin
         mem[mem_addr] <= {mark, days_ff, urg_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_rd) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   // update pointers, counts and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_LINES; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
         arrival_ff <= '0;
         served_ff  <= '0;
      end else begin
         if (cmd.push) begin
            arrival_ff <= arrival_ff + AcW'(1);
            if (!line_full) begin
               tail_ff[sel_ff] <= next_ptr(sel_tail);
               cnt_ff[sel_ff]  <= sel_cnt + CW'(1);
            end
         end
         if (cmd.pop) begin
            head_ff[sel_ff] <= next_ptr(sel_head);
            cnt_ff[sel_ff]  <= sel_cnt - CW'(1);
            served_ff       <= served_ff + SvW'(1);
         end
      end
   end

   // result register
   logic                rsp_valid_ff;
   mqpha_pkg::rsp_type  rsp_ff, rsp_in;
   logic [4:0]          line_num;

   assign line_num = 5'(32'(sel_ff) + 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push || cmd.pop || cmd.rsp_empty) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // build the next result
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.push) begin
         rsp_in        = '0;
         rsp_in.status = line_full ? mqpha_pkg::StatusFull : mqpha_pkg::StatusOk;
         rsp_in.line   = line_num;
      end else if (cmd.pop) begin
         rsp_in.status         = mqpha_pkg::StatusOk;
         rsp_in.line           = line_num;
         rsp_in.served_days    = best_data_ff[31:16];
         rsp_in.served_urgency = best_data_ff[15:0];
         rsp_in.is_target      = best_data_ff[32];
         rsp_in.order_number   = served_ff;
      end else if (cmd.rsp_empty) begin
         rsp_in        = '0;
         rsp_in.status = mqpha_pkg::StatusEmpty;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign stat.div_done   = (div_cnt_ff == 4'(AcW));
   assign stat.scan_last  = scan_last;
   assign stat.best_found = best_found_ff;
   assign stat.rsp_busy   = rsp_valid_ff && rsp_stall;

endmodule
